FILE: src/pdot_pkg.sv
// Shared types and constants of the periodic deadline overrun tracker.
// No dependencies; imported by the controller, the datapath and the top level.
package pdot_pkg;

    localparam int TIME_W    = 64;
    localparam int REG_W     = 40;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_STEPS = TIME_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [REG_W-1:0] PERIOD_RESET = REG_W'(1000000);
    localparam logic [REG_W-1:0] OFFSET_RESET = '0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(1);

    // item kinds
    localparam logic ACT_ARM    = 1'b0;
    localparam logic ACT_WAKEUP = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;    // latch the accepted item
        logic div_load_t; // start divide of the item's time stamp by period
        logic div_load_d; // start divide of (stamp - deadline) by period
        logic div_step;   // one restoring divide step
        logic sum_set;    // sum = stamp + (period - remainder)
        logic arm_set;    // deadline = sum + offset, armed
        logic cmp;        // diff = stamp - deadline, late flag
        logic wk_late;    // deadline = sum, missed = quotient
        logic wk_early;   // deadline = deadline + period
        logic out_load;   // copy results into the output register
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic action;
        logic armed;
        logic late;
    } t_stat;

endpackage

FILE: src/pdot_ctrl.sv
// Sequencing controller of the periodic deadline overrun tracker.
// Depends on pdot_pkg; drives pdot_datapath through t_cmd and reads t_stat.
module pdot_ctrl
    import pdot_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_action,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARM_START,
        S_ARM_DIV,
        S_ARM_SUM,
        S_ARM_SET,
        S_WK_CMP,
        S_WK_DEC,
        S_WK_DIV,
        S_WK_SUM,
        S_WK_SET,
        S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic             w_accept;
    logic             w_out_free;
    logic             w_div_last;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_valid || !i_stall;
    assign w_div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    if (!i_stat.armed) begin
                        n_state = S_ARM_START;
                    end else if (i_action == ACT_WAKEUP) begin
                        n_state = S_WK_CMP;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_ARM_START: begin
                o_cmd.div_load_t = 1'b1;
                n_cnt            = '0;
                n_state          = S_ARM_DIV;
            end
            S_ARM_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (w_div_last) begin
                    n_state = S_ARM_SUM;
                end
            end
            S_ARM_SUM: begin
                o_cmd.sum_set = 1'b1;
                n_state       = S_ARM_SET;
            end
            S_ARM_SET: begin
                o_cmd.arm_set = 1'b1;
                n_state       = (i_stat.action == ACT_WAKEUP) ? S_WK_CMP : S_OUT;
            end
            S_WK_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_WK_DEC;
            end
            S_WK_DEC: begin
                if (i_stat.late) begin
                    o_cmd.div_load_d = 1'b1;
                    n_cnt            = '0;
                    n_state          = S_WK_DIV;
                end else begin
                    o_cmd.wk_early = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_WK_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (w_div_last) begin
                    n_state = S_WK_SUM;
                end
            end
            S_WK_SUM: begin
                o_cmd.sum_set = 1'b1;
                n_state       = S_WK_SET;
            end
            S_WK_SET: begin
                o_cmd.wk_late = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // wait until the output register is free
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

endmodule

FILE: src/pdot_datapath.sv
// Datapath of the periodic deadline overrun tracker: configuration, deadline
// state, a shared restoring divider and the output register. Depends on pdot_pkg.
module pdot_datapath
    import pdot_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  logic                 i_action,
    input  logic [TIME_W-1:0]    i_stamp_ns,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic [TIME_W-1:0]    o_missed_count,
    output logic [TIME_W-1:0]    o_next_deadline,
    output logic                 o_armed
);

    logic [REG_W-1:0]  r_period;
    logic [REG_W-1:0]  r_offset;
    logic              r_armed;
    logic [TIME_W-1:0] r_deadline;
    logic              r_action;
    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] r_missed;
    logic [TIME_W-1:0] r_diff;
    logic              r_late;
    logic [TIME_W-1:0] r_sum;
    logic [REG_W-1:0]  r_rem;
    logic [TIME_W-1:0] r_quo;
    logic [TIME_W-1:0] r_out_missed;
    logic [TIME_W-1:0] r_out_deadline;
    logic              r_out_armed;

    logic [REG_W-1:0]  w_period;
    logic [REG_W:0]    w_rem_sh;
    logic              w_ge;
    logic [REG_W:0]    w_rem_sub;
    logic [TIME_W:0]   w_diff;

    // a zero period counts as one
    assign w_period = (r_period == '0) ? REG_W'(1) : r_period;

    // one restoring divide step
    assign w_rem_sh  = {r_rem, r_quo[TIME_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, w_period});
    assign w_rem_sub = w_rem_sh - {1'b0, w_period};

    // stamp - deadline with borrow
    assign w_diff = {1'b0, r_time} - {1'b0, r_deadline};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PERIOD: r_period <= i_cfg_data;
                REG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // deadline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_deadline <= '0;
        end else begin
            if (i_cmd.arm_set) begin
                r_armed    <= 1'b1;
                r_deadline <= r_sum + {{(TIME_W-REG_W){1'b0}}, r_offset};
            end else if (i_cmd.wk_late) begin
                r_deadline <= r_sum;
            end else if (i_cmd.wk_early) begin
                r_deadline <= r_deadline + {{(TIME_W-REG_W){1'b0}}, w_period};
            end
        end
    end

    // item, compare and sum registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_time   <= i_stamp_ns;
        end
        if (i_cmd.load_in) begin
            r_missed <= '0;
        end else if (i_cmd.wk_late) begin
            r_missed <= r_quo;
        end
        if (i_cmd.cmp) begin
            r_diff <= w_diff[TIME_W-1:0];
            r_late <= !w_diff[TIME_W] && (w_diff[TIME_W-1:0] != '0);
        end
        // remainder < period, so period - remainder fits the register width
        if (i_cmd.sum_set) begin
            r_sum <= r_time + {{(TIME_W-REG_W){1'b0}}, w_period - r_rem};
        end
    end

    // shared divider: quotient shifts out the dividend, remainder builds up
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load_t) begin
            r_quo <= r_time;
            r_rem <= '0;
        end else if (i_cmd.div_load_d) begin
            r_quo <= r_diff;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[TIME_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[REG_W-1:0] : w_rem_sh[REG_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_missed   <= r_missed;
            r_out_deadline <= r_deadline;
            r_out_armed    <= r_armed;
        end
    end

    assign o_stat.action   = r_action;
    assign o_stat.armed    = r_armed;
    assign o_stat.late     = r_late;
    assign o_missed_count  = r_out_missed;
    assign o_next_deadline = r_out_deadline;
    assign o_armed         = r_out_armed;

endmodule

FILE: src/periodic_deadline_overrun_tracker.sv
// Top level of the periodic deadline overrun tracker.
// Depends on pdot_pkg, pdot_ctrl and pdot_datapath.
//
// Tracks one periodic deadline in nanoseconds. An arm item (action 0) sets the
// deadline to the next whole multiple of period_ns after the item's time stamp
// plus offset_ns; it is ignored once armed. A wakeup item (action 1) arms first
// if needed, then reports the whole periods missed past the deadline and moves
// the deadline forward by missed + 1 periods, wrapping modulo 2^64. Every item
// gives one result. Remainder and missed count come from one shared restoring
// divider that retires one quotient bit a cycle. An arm item divides its time
// stamp by the period, forms the sum and sets the deadline; an on-time wakeup
// compares and steps the deadline by one period; a late wakeup compares,
// divides the overrun, forms the sum and sets the deadline; an unarmed wakeup
// arms first. An ignored arm goes straight to the output. A finished item waits
// in its last state while the previous result is still stalled. One item is in
// work at a time; the output register holds a finished result while the next
// item is taken. Configuration writes are always ready; the user must make them
// only while the block is idle, which the block itself does not enforce.
module periodic_deadline_overrun_tracker
    import pdot_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_action,
    input  logic [TIME_W-1:0]    i_stamp_ns,
    // result items
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [TIME_W-1:0]    o_missed_count,
    output logic [TIME_W-1:0]    o_next_deadline,
    output logic                 o_armed
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    pdot_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    pdot_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_stamp_ns      (i_stamp_ns),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_missed_count  (o_missed_count),
        .o_next_deadline (o_next_deadline),
        .o_armed         (o_armed)
    );

endmodule

FILE: test/pdot_checker.sv
// Result checker for the periodic deadline overrun tracker testbench.
// Depends on pdot_pkg; watches the configuration, item and result channels.
`timescale 1ns / 100ps

module pdot_checker
    import pdot_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration channel
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    // item channel
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_action,
    input  logic [TIME_W-1:0]    i_stamp_ns,
    // result channel
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [TIME_W-1:0]    i_missed_count,
    input  logic [TIME_W-1:0]    i_next_deadline,
    input  logic                 i_armed,
    // status for the stimulus side
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_late,
    output logic [TIME_W-1:0]    o_deadline_ahead
);

    typedef struct packed {
        logic [TIME_W-1:0] missed;
        logic [TIME_W-1:0] deadline;
        logic              armed;
    } t_tracker_result;

    logic [REG_W-1:0]  period_q;
    logic [REG_W-1:0]  offset_q;
    logic              armed_q;
    logic [TIME_W-1:0] deadline_q;

    t_tracker_result   offered;
    t_tracker_result   results_due[$];

    // Deadline bookkeeping for one item, all sums wrapping at 64 bits
    function automatic t_tracker_result track_deadline(
        input logic              act,
        input logic [TIME_W-1:0] t,
        input logic              was_armed,
        input logic [TIME_W-1:0] dl,
        input logic [REG_W-1:0]  per,
        input logic [REG_W-1:0]  ofs
    );
        logic [TIME_W-1:0] p;
        t_tracker_result   r;
        p = (per == '0) ? TIME_W'(1) : TIME_W'(per);
        r.missed   = '0;
        r.deadline = dl;
        r.armed    = 1'b1;
        // first item aligns to the next global slot, then adds the phase
        if (!was_armed)
            r.deadline = t + (p - (t % p)) + TIME_W'(ofs);
        if (act == ACT_WAKEUP) begin
            if (t > r.deadline)
                r.missed = (t - r.deadline) / p;
            r.deadline = r.deadline + (r.missed + TIME_W'(1)) * p;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want, inout int fails);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    // outcome of the item on offer; committed when it is accepted
    always_comb offered = track_deadline(i_action, i_stamp_ns, armed_q, deadline_q,
                                         period_q, offset_q);

    assign o_deadline_ahead = i_in_valid ? offered.deadline : deadline_q;

    // register shadow, expected results and comparison
    always @(posedge i_clk) begin : track
        t_tracker_result want;
        int              fails;
        fails = 0;
        if (!i_rst_n) begin
            period_q   <= PERIOD_RESET;
            offset_q   <= OFFSET_RESET;
            armed_q    <= 1'b0;
            deadline_q <= '0;
            results_due.delete();
            o_errors   <= 0;
            o_pending  <= 0;
            o_checked  <= 0;
            o_late     <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_PERIOD)
                    period_q <= i_cfg_data;
                else if (i_cfg_index == REG_OFFSET)
                    offset_q <= i_cfg_data;
            end
            // results are matched before new items are queued
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: missed_count %0d next_deadline %0d",
                           i_missed_count, i_next_deadline);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    check_field("missed_count", i_missed_count, want.missed, fails);
                    check_field("next_deadline", i_next_deadline, want.deadline, fails);
                    check_field("armed", TIME_W'(i_armed), TIME_W'(want.armed), fails);
                end
                o_checked <= o_checked + 1;
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(offered);
                armed_q    <= offered.armed;
                deadline_q <= offered.deadline;
                if (offered.missed != '0)
                    o_late <= o_late + 1;
            end
            o_errors  <= o_errors + fails;
            o_pending <= results_due.size();
        end
    end

endmodule

FILE: test/periodic_deadline_overrun_tracker_tb.sv
// Testbench top for the periodic deadline overrun tracker: clock, reset,
// stimulus and verdict. Depends on pdot_pkg, pdot_checker and the tracker RTL.
`timescale 1ns / 100ps

module periodic_deadline_overrun_tracker_tb;
    import pdot_pkg::*;

    localparam int NUM_PHASES     = 8;
    localparam int N_WAKEUPS      = 1140;
    localparam int DIRECTED_ITEMS = 18;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    localparam logic [REG_W-1:0]     REG_MAX    = '1;
    localparam logic [TIME_W-1:0]    TIME_MAX   = '1;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = REG_OFFSET + 1'b1;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_action    = ACT_ARM;
    logic [TIME_W-1:0]    i_stamp_ns  = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [TIME_W-1:0]    o_missed_count;
    logic [TIME_W-1:0]    o_next_deadline;
    logic                 o_armed;

    int                   chk_errors;
    int                   chk_pending;
    int                   chk_checked;
    int                   chk_late;
    logic [TIME_W-1:0]    dl_ahead;

    logic [REG_W-1:0]     cur_period = PERIOD_RESET;
    int                   burst_left = 0;
    int                   n_wakeups  = 0;
    int                   n_arms     = 0;
    int                   n_settings = 0;
    t_rx_mode             rx_mode    = RX_FREE;
    int                   rx_left    = 0;
    int                   idle_cycles = 0;

    periodic_deadline_overrun_tracker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_stamp_ns      (i_stamp_ns),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_missed_count  (o_missed_count),
        .o_next_deadline (o_next_deadline),
        .o_armed         (o_armed)
    );

    pdot_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_action         (i_action),
        .i_stamp_ns       (i_stamp_ns),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_missed_count   (o_missed_count),
        .i_next_deadline  (o_next_deadline),
        .i_armed          (o_armed),
        .o_errors         (chk_errors),
        .o_pending        (chk_pending),
        .o_checked        (chk_checked),
        .o_late           (chk_late),
        .o_deadline_ahead (dl_ahead)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure: free, light or heavy stretches of random length
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(2, 0));
            rx_left <= $urandom_range(300, 20);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(3, 0) == 0);
            default:  i_stall <= ($urandom_range(3, 0) != 0);
        endcase
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, chk_pending);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // wakeup time around the current deadline, from a little early to far late, plus some random and extreme stamps
    function automatic logic [TIME_W-1:0] aim_time(input logic [TIME_W-1:0] dl,
                                                   input logic [REG_W-1:0] per);
        logic [TIME_W-1:0] p;
        logic [TIME_W-1:0] frac;
        p    = TIME_W'(per);
        frac = rand64() % p;
        case ($urandom_range(15, 0))
            0, 1:    return dl;
            2, 3:    return dl - TIME_W'(1) - frac;
            4, 5, 6: return dl + frac;
            7, 8:    return dl + TIME_W'($urandom_range(3, 1)) * p + frac;
            9:       return dl + TIME_W'($urandom_range(4, 1)) * p;
            10, 11:  return dl + TIME_W'($urandom_range(1 << 20, 5)) * p + frac;
            12:      return rand64();
            13:      return TIME_MAX - TIME_W'($urandom_range(1000, 0));
            14:      return TIME_W'($urandom_range(1000, 0));
            default: return dl + TIME_W'(1);
        endcase
    endfunction

    // offer one item, wait for it to be taken, then maybe go quiet for a while
    task automatic send_item(input logic act, input logic [TIME_W-1:0] t);
        i_valid    <= 1'b1;
        i_action   <= act;
        i_stamp_ns <= t;
        do @(posedge i_clk); while (o_stall);
        if (act == ACT_WAKEUP)
            n_wakeups++;
        else
            n_arms++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            if ($urandom_range(3, 0) == 0)
                repeat ($urandom_range(90, 20)) @(posedge i_clk);
            else
                repeat ($urandom_range(6, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 10)
                                                     : $urandom_range(6, 0);
        end
    endtask

    // stop sending and wait until every item has produced its result
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    // leaves i_cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_timing(input logic [REG_W-1:0] per, input logic [REG_W-1:0] ofs,
                              input logic poke_unused);
        wait_idle();
        if (poke_unused)
            write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, IDX_UNUSED)),
                      REG_W'(rand64()));
        write_reg(REG_PERIOD, per);
        write_reg(REG_OFFSET, ofs);
        i_cfg_valid <= 1'b0;
        cur_period = per;
        n_settings++;
    endtask

    initial begin
        int                i;
        int                ph;
        int                target;
        logic              act;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] p;
        logic [REG_W-1:0]  per_v;
        logic [REG_W-1:0]  ofs_v;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first item is a wakeup while unarmed, at an exact multiple
        // near the top of the clock so the aligned deadline wraps
        set_timing(REG_W'(1000), REG_MAX, 1'b1);
        p = TIME_W'(cur_period);
        send_item(ACT_WAKEUP, (TIME_MAX / p) * p);
        for (i = 0; i < DIRECTED_ITEMS; i++) begin
            if (i == 11)
                set_timing(REG_W'(1), '0, 1'b0);
            if (i == 14)
                set_timing(REG_MAX, REG_MAX, 1'b0);
            p   = TIME_W'(cur_period);
            act = ACT_WAKEUP;
            case (i)
                0:  begin act = ACT_ARM; t = '0; end       // arm while armed
                1:  begin act = ACT_ARM; t = TIME_MAX; end
                2:  t = dl_ahead;                          // right on the deadline
                3:  t = dl_ahead - TIME_W'(1);
                4:  t = dl_ahead + TIME_W'(1);
                5:  t = dl_ahead + p;
                6:  t = dl_ahead + TIME_W'(2) * p - TIME_W'(1);
                7:  t = dl_ahead + TIME_W'(7) * p;
                8:  t = '0;
                9:  t = TIME_MAX;
                10: t = TIME_MAX;
                11: t = dl_ahead;
                12: t = dl_ahead + TIME_W'(5);
                13: begin act = ACT_ARM; t = rand64(); end
                14: t = dl_ahead + p - TIME_W'(1);
                15: t = dl_ahead + TIME_W'(3) * p;
                16: t = rand64();
                default: t = dl_ahead;
            endcase
            send_item(act, t);
        end

        // random phases, each under its own period and offset
        target = n_wakeups;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 6)
                0: per_v = PERIOD_RESET;
                1: per_v = REG_W'(1);
                2: per_v = REG_MAX;
                3: per_v = REG_W'($urandom_range(1000, 2));
                4: per_v = REG_W'(rand64()) | REG_W'(1);
                default: per_v = REG_W'($urandom_range(1 << 20, 1));
            endcase
            case (ph % 3)
                0: ofs_v = '0;
                1: ofs_v = REG_MAX;
                default: ofs_v = REG_W'(rand64());
            endcase
            set_timing(per_v, ofs_v, (ph % 3) == 2);
            target += N_WAKEUPS / NUM_PHASES;
            while (n_wakeups < target) begin
                if ($urandom_range(11, 0) == 0)
                    send_item(ACT_ARM, rand64());
                else
                    send_item(ACT_WAKEUP, aim_time(dl_ahead, cur_period));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d wakeups, %0d arm requests) under %0d timing settings",
                 n_wakeups + n_arms, n_wakeups, n_arms, n_settings);
        $display("Compared %0d results; %0d wakeups overran their deadline",
                 chk_checked, chk_late);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
